@@ rtl/line_or_json_object_framer_top_defines.svh @@
// Assertion helpers for the framer; include once per asserting file.
`ifndef LINE_OR_JSON_OBJECT_FRAMER_TOP_DEFINES_SVH
`define LINE_OR_JSON_OBJECT_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LOJF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LOJF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

@@ rtl/lojf_pkg.sv @@
// ----------------------------------------------------------------------------
// lojf_pkg
// Shared character codes, event codes and result word type of the framer.
// ----------------------------------------------------------------------------
`default_nettype none

package lojf_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_OPEN      = 8'h7B;
    localparam logic [7:0] CH_CLOSE     = 8'h7D;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] DEPTH_MAX    = 8'hFF;

    localparam logic [2:0] EV_STORED     = 3'd0;
    localparam logic [2:0] EV_OBJECT_END = 3'd1;
    localparam logic [2:0] EV_LINE_END   = 3'd2;
    localparam logic [2:0] EV_EMPTY_LINE = 3'd3;
    localparam logic [2:0] EV_OVERFLOW   = 3'd4;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] data_byte;
        logic [8:0] byte_index;
        logic [8:0] frame_length;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/lojf_if.sv @@
// ----------------------------------------------------------------------------
// lojf_if
// Valid/ready channels of the framer: received bytes in, events out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lojf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lojf_ev_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic [8:0] frame_length;

    modport source (output valid, output event_kind, output data_byte,
                    output byte_index, output frame_length, input ready);
    modport sink   (input valid, input event_kind, input data_byte,
                    input byte_index, input frame_length, output ready);
endinterface

`default_nettype wire

@@ rtl/lojf_tracker.sv @@
// ----------------------------------------------------------------------------
// lojf_tracker
// Frame state registers and the per-byte framing and JSON tracking step.
// ----------------------------------------------------------------------------
`default_nettype none

module lojf_tracker
    import lojf_pkg::*;
#(
    parameter int FRAME_CAPACITY = 384
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_result    o_result
);

    localparam int CW = $clog2(FRAME_CAPACITY);
    localparam int XW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(FRAME_CAPACITY - 1);

    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_depth, n_depth;
    logic          r_in_str, n_in_str;
    logic          r_esc, n_esc;

    logic [7:0]    j_depth;
    logic          j_in_str;
    logic          j_esc;
    logic          j_close;
    logic [CW-1:0] w_inc;
    logic [CW-1:0] w_idx;
    logic [CW-1:0] w_len;
    logic [XW-1:0] w_idx_x;
    logic [XW-1:0] w_len_x;
    logic [2:0]    w_kind;

    // JSON tracker step on the stored path
    always_comb begin
        j_depth  = r_depth;
        j_in_str = r_in_str;
        j_esc    = r_esc;
        j_close  = 1'b0;
        if (r_in_str) begin
            if (r_esc) begin
                j_esc = 1'b0;
            end else if (i_rx_byte == CH_BACKSLASH) begin
                j_esc = 1'b1;
            end else if (i_rx_byte == CH_QUOTE) begin
                j_in_str = 1'b0;
            end
        end else if (i_rx_byte == CH_QUOTE) begin
            j_in_str = 1'b1;
        end else if (i_rx_byte == CH_OPEN) begin
            if (r_depth != DEPTH_MAX) begin
                j_depth = r_depth + 8'd1;
            end
        end else if (i_rx_byte == CH_CLOSE && r_depth != 8'd0) begin
            j_depth = r_depth - 8'd1;
            j_close = (r_depth == 8'd1);
        end
    end

    assign w_inc = r_count + CW'(1);

    // frame decision
    always_comb begin
        n_count  = r_count;
        n_depth  = r_depth;
        n_in_str = r_in_str;
        n_esc    = r_esc;
        w_idx    = '0;
        w_len    = '0;
        if (i_rx_byte == CH_CR || i_rx_byte == CH_LF) begin
            if (r_count != '0) begin
                w_kind   = EV_LINE_END;
                w_len    = r_count;
                n_count  = '0;
                n_depth  = '0;
                n_in_str = 1'b0;
                n_esc    = 1'b0;
            end else begin
                w_kind = EV_EMPTY_LINE;
            end
        end else if (r_count < COUNT_LIMIT) begin
            w_idx = r_count;
            w_len = w_inc;
            if (j_close) begin
                w_kind   = EV_OBJECT_END;
                n_count  = '0;
                n_depth  = '0;
                n_in_str = 1'b0;
                n_esc    = 1'b0;
            end else begin
                w_kind   = EV_STORED;
                n_count  = w_inc;
                n_depth  = j_depth;
                n_in_str = j_in_str;
                n_esc    = j_esc;
            end
        end else begin
            w_kind   = EV_OVERFLOW;
            n_count  = '0;
            n_depth  = '0;
            n_in_str = 1'b0;
            n_esc    = 1'b0;
        end
    end

    // report counts in the low nine bits
    assign w_idx_x = XW'(w_idx);
    assign w_len_x = XW'(w_len);

    assign o_result.event_kind   = w_kind;
    assign o_result.data_byte    = i_rx_byte;
    assign o_result.byte_index   = w_idx_x[8:0];
    assign o_result.frame_length = w_len_x[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
        end else if (i_accept) begin
            r_count  <= n_count;
            r_depth  <= n_depth;
            r_in_str <= n_in_str;
            r_esc    <= n_esc;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lojf_out_buf.sv @@
// ----------------------------------------------------------------------------
// lojf_out_buf
// Two-word result buffer; parts the input handshake from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lojf_out_buf
    import lojf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill, n_fill;

    assign o_space = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

@@ rtl/line_or_json_object_framer_top.sv @@
// ----------------------------------------------------------------------------
// line_or_json_object_framer_top
// Frames a received byte stream by line ends and top-level JSON objects.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries one received byte per word. o_ev returns exactly one event
//   word per byte: the event kind (stored, object closed the frame, line end
//   closed the frame, empty line end, overflow drop), the byte echoed, its
//   index in the frame and the frame length after it.
//   Event words are registered in the result buffer in byte order.
//   Throughput: one byte per cycle while the buffer has room; the frame
//   state is updated in the accepting cycle by one compare/increment pass.
//   Stall: results wait in a two-word buffer. i_rx.ready comes from the
//   buffer fill register and drops only when both words are held, so the
//   input keeps flowing while one result waits.
//   Reset: synchronous, active low; clears the frame count, object depth,
//   string and escape flags, and empties the result buffer.
//   FRAME_CAPACITY sets the stored-count width; counts are reported in the
//   low nine bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_or_json_object_framer_top_defines.svh"

module line_or_json_object_framer_top
    import lojf_pkg::*;
#(
    parameter int FRAME_CAPACITY = 384
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lojf_rx_if.sink  i_rx,
    lojf_ev_if.source o_ev
);

    logic    w_accept;
    logic    w_space;
    logic    w_pop;
    t_result w_step;
    t_result w_head;

    // take a byte whenever the buffer has room
    assign i_rx.ready = w_space;
    assign w_accept   = i_rx.valid && w_space;
    assign w_pop      = o_ev.valid && o_ev.ready;

    lojf_tracker #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx.rx_byte),
        .o_result  (w_step)
    );

    // hold results until the receiver takes them
    lojf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_step),
        .o_space (w_space),
        .o_valid (o_ev.valid),
        .i_pop   (w_pop),
        .o_data  (w_head)
    );

    assign o_ev.event_kind   = w_head.event_kind;
    assign o_ev.data_byte    = w_head.data_byte;
    assign o_ev.byte_index   = w_head.byte_index;
    assign o_ev.frame_length = w_head.frame_length;

    // stored bytes always extend the frame by one
    `LOJF_ASSERT_NOW(a_stored_len, i_clk, i_rst_n,
        o_ev.valid && (o_ev.event_kind == EV_STORED || o_ev.event_kind == EV_OBJECT_END),
        o_ev.frame_length == o_ev.byte_index + 9'd1)

    // bytes that are not stored carry index zero
    `LOJF_ASSERT_NOW(a_drop_index, i_clk, i_rst_n,
        o_ev.valid && (o_ev.event_kind == EV_LINE_END || o_ev.event_kind == EV_EMPTY_LINE
            || o_ev.event_kind == EV_OVERFLOW),
        o_ev.byte_index == 9'd0)

    // a byte taken from an empty buffer appears on the output next cycle
    `LOJF_ASSERT_NEXT(a_latency, i_clk, i_rst_n,
        w_accept && !o_ev.valid,
        o_ev.valid && o_ev.data_byte == $past(i_rx.rx_byte))

endmodule

`default_nettype wire

@@ tb/line_or_json_object_framer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_or_json_object_framer_top_tb
// Self-checking bench for the byte framer: a short directed script of line
// ends, braces, quotes and escapes, then random JSON objects, text lines,
// noise, deep nesting and frame overflow, each word checked against a
// cycle-free model of the framing rules or against its listed script result.
// ----------------------------------------------------------------------------
module line_or_json_object_framer_top_tb;
    import lojf_pkg::*;

    localparam int FRAME_CAP   = 384;
    localparam int ITEM_TARGET = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 80;

    // One row of the directed script. Rows with typed set carry a result that
    // is plain from the rules; the rest fall back to the framing model.
    typedef struct {
        logic [7:0] rx_byte;
        bit         typed;
        t_result    want;
    } t_script_row;

    localparam int SCRIPT_LEN = 25;

    logic i_clk;
    logic i_rst_n;

    lojf_rx_if rx_ch ();
    lojf_ev_if ev_ch ();

    line_or_json_object_framer_top #(
        .FRAME_CAPACITY(FRAME_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_ch),
        .o_ev   (ev_ch)
    );

    // Directed script: empty line ends after reset, a lone closing brace,
    // byte extremes, escaped quotes and braces inside strings, line ends
    // inside an object and inside a string, a nested object that closes its
    // frame, and a backslash outside any string.
    t_script_row script [SCRIPT_LEN] = '{
        '{CH_LF,        1'b1, '{EV_EMPTY_LINE, CH_LF,    9'd0, 9'd0}},
        '{CH_CR,        1'b1, '{EV_EMPTY_LINE, CH_CR,    9'd0, 9'd0}},
        '{CH_CLOSE,     1'b1, '{EV_STORED,     CH_CLOSE, 9'd0, 9'd1}},
        '{8'h00,        1'b1, '{EV_STORED,     8'h00,    9'd1, 9'd2}},
        '{8'hFF,        1'b1, '{EV_STORED,     8'hFF,    9'd2, 9'd3}},
        '{CH_CR,        1'b1, '{EV_LINE_END,   CH_CR,    9'd0, 9'd3}},
        '{CH_OPEN,      1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_QUOTE,     1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_BACKSLASH, 1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_QUOTE,     1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_CLOSE,     1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_QUOTE,     1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_LF,        1'b1, '{EV_LINE_END,   CH_LF,    9'd0, 9'd6}},
        '{CH_OPEN,      1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_QUOTE,     1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_CR,        1'b1, '{EV_LINE_END,   CH_CR,    9'd0, 9'd2}},
        '{CH_OPEN,      1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_OPEN,      1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_CLOSE,     1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_CLOSE,     1'b1, '{EV_OBJECT_END, CH_CLOSE, 9'd3, 9'd4}},
        '{CH_LF,        1'b1, '{EV_EMPTY_LINE, CH_LF,    9'd0, 9'd0}},
        '{CH_BACKSLASH, 1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_QUOTE,     1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_BACKSLASH, 1'b0, '{EV_STORED,     8'h00,    9'd0, 9'd0}},
        '{CH_LF,        1'b1, '{EV_LINE_END,   CH_LF,    9'd0, 9'd3}}
    };

    // Framing model state, advanced once per accepted byte.
    int unsigned held_count  = 0;
    logic [7:0]  brace_depth = '0;
    logic        in_quote    = 1'b0;
    logic        esc_armed   = 1'b0;

    t_result     events_due [$];     // event words owed by the block, oldest first
    t_result     predicted;
    t_result     oldest;
    int          cur_tag;            // script row riding along with rx_byte, -1 if random
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          sent_count  = 0;
    int          burst_left  = 0;

    // Long receiver hold-off: the sender bumps hold_reqs, the receiver counts.
    int          hold_reqs   = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          rx_mode     = 0;
    int          mode_left   = 0;

    // Clock: 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog: run stuck after %0d cycles, %0d words outstanding",
                     cycle_count, events_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void drop_frame();
        held_count  = 0;
        brace_depth = '0;
        in_quote    = 1'b0;
        esc_armed   = 1'b0;
    endfunction

    // Framing rules: line ends close a non-empty frame, a closing brace that
    // returns depth to zero closes the frame, and a byte past capacity minus
    // one is dropped with the whole frame.
    function automatic t_result frame_next(input logic [7:0] b);
        t_result r;
        logic    closed;
        r.event_kind   = EV_STORED;
        r.data_byte    = b;
        r.byte_index   = '0;
        r.frame_length = '0;
        closed         = 1'b0;
        if (b == CH_CR || b == CH_LF) begin
            if (held_count != 0) begin
                r.event_kind   = EV_LINE_END;
                r.frame_length = held_count[8:0];
                drop_frame();
            end else begin
                r.event_kind = EV_EMPTY_LINE;
            end
        end else if (held_count < FRAME_CAP - 1) begin
            r.byte_index   = held_count[8:0];
            held_count++;
            r.frame_length = held_count[8:0];
            if (in_quote) begin
                if (esc_armed)
                    esc_armed = 1'b0;
                else if (b == CH_BACKSLASH)
                    esc_armed = 1'b1;
                else if (b == CH_QUOTE)
                    in_quote = 1'b0;
            end else if (b == CH_QUOTE) begin
                in_quote = 1'b1;
            end else if (b == CH_OPEN) begin
                if (brace_depth != DEPTH_MAX)
                    brace_depth++;
            end else if (b == CH_CLOSE && brace_depth != 0) begin
                brace_depth--;
                closed = (brace_depth == 0);
            end
            if (closed) begin
                r.event_kind = EV_OBJECT_END;
                drop_frame();
            end
        end else begin
            r.event_kind = EV_OVERFLOW;
            drop_frame();
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("[cycle %0d] mismatch on %s: got %0d, expected %0d",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    // Any byte except a line end.
    function automatic logic [7:0] pick_no_eol();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // A byte with no framing meaning: no line end, quote or brace.
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = pick_no_eol();
        while (b == CH_QUOTE || b == CH_OPEN || b == CH_CLOSE);
        return b;
    endfunction

    // Offer one byte and hold it until taken. Between bursts drop valid for
    // a random gap; within a burst keep valid high across words.
    task automatic send_byte(input logic [7:0] b, input int tag);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        cur_tag       <= tag;
        do @(posedge i_clk);
        while (!rx_ch.ready);
        burst_left--;
        sent_count++;
    endtask

    // Stall until the block has returned every word owed.
    task automatic drain_pause();
        rx_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk);
        while (events_due.size() != 0);
    endtask

    // Receiver: switch between always-ready, coin-flip, mostly-ready and a
    // fixed stutter pattern; honor a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ev_ch.ready <= 1'b0;
        end else begin
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                ev_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: ev_ch.ready <= 1'b1;
                    1: ev_ch.ready <= 1'($urandom_range(0, 1));
                    2: ev_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: ev_ch.ready <= ((cycle_count % 7) < 3);
                endcase
            end
        end
    end

    // Scoreboard: predict on every byte taken, then compare every event word
    // handed out against the oldest prediction. Prediction comes first so a
    // same-edge result would still find its expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                predicted = frame_next(rx_ch.rx_byte);
                if (cur_tag >= 0 && script[cur_tag].typed)
                    events_due.push_back(script[cur_tag].want);
                else
                    events_due.push_back(predicted);
            end
            if (ev_ch.valid && ev_ch.ready) begin
                if (events_due.size() == 0) begin
                    note_mismatch("unexpected event word, data_byte", ev_ch.data_byte, 0);
                end else begin
                    oldest = events_due.pop_front();
                    if (ev_ch.event_kind !== oldest.event_kind)
                        note_mismatch("event_kind", ev_ch.event_kind, oldest.event_kind);
                    if (ev_ch.data_byte !== oldest.data_byte)
                        note_mismatch("data_byte", ev_ch.data_byte, oldest.data_byte);
                    if (ev_ch.byte_index !== oldest.byte_index)
                        note_mismatch("byte_index", ev_ch.byte_index, oldest.byte_index);
                    if (ev_ch.frame_length !== oldest.frame_length)
                        note_mismatch("frame_length", ev_ch.frame_length,
                                      oldest.frame_length);
                end
            end
        end
    end

    initial begin
        int seq_no;
        int kind;
        int lvl;
        int n;
        int m;
        int cut;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        cur_tag       = -1;

        // Hold reset, then release it on a rising edge.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script.
        for (int i = 0; i < SCRIPT_LEN; i++)
            send_byte(script[i].rx_byte, i);

        // Random traffic, built from sequences.
        seq_no = 0;
        while (sent_count < ITEM_TARGET) begin
            if (seq_no == 4)
                kind = 4;                         // force one deep nesting run
            else if (seq_no == 9)
                kind = 3;                         // force one overflow run
            else begin
                kind = $urandom_range(0, 99);
                kind = (kind < 50) ? 0 : (kind < 75) ? 1 : (kind < 94) ? 2 :
                       (kind < 97) ? 3 : 4;
            end

            // Exercise backpressure: long receiver hold-off while bytes keep
            // coming, and a full drain now and then.
            if (seq_no % 17 == 5)
                hold_reqs++;
            if (seq_no % 23 == 11)
                drain_pause();

            case (kind)
                0: begin
                    // Well-formed object with strings, escapes and nesting;
                    // a few are cut by a line end or left open.
                    if ($urandom_range(0, 3) != 0)
                        send_byte(CH_LF, -1);
                    send_byte(CH_OPEN, -1);
                    lvl = 1;
                    n   = $urandom_range(2, 30);
                    for (int k = 0; k < n; k++) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: begin
                                send_byte(CH_QUOTE, -1);
                                m = $urandom_range(0, 8);
                                for (int j = 0; j < m; j++) begin
                                    if ($urandom_range(0, 4) == 0) begin
                                        send_byte(CH_BACKSLASH, -1);
                                        send_byte(pick_no_eol(), -1);
                                    end else begin
                                        logic [7:0] sb;
                                        do sb = pick_no_eol();
                                        while (sb == CH_QUOTE || sb == CH_BACKSLASH);
                                        send_byte(sb, -1);
                                    end
                                end
                                send_byte(CH_QUOTE, -1);
                            end
                            3: if (lvl < 6) begin
                                send_byte(CH_OPEN, -1);
                                lvl++;
                            end
                            4: if (lvl > 1) begin
                                send_byte(CH_CLOSE, -1);
                                lvl--;
                            end
                            default: send_byte(pick_plain(), -1);
                        endcase
                    end
                    cut = $urandom_range(0, 9);
                    if (cut == 0)
                        send_byte(CH_LF, -1);
                    else if (cut != 1)
                        while (lvl > 0) begin
                            send_byte(CH_CLOSE, -1);
                            lvl--;
                        end
                end
                1: begin
                    // Text line with CR, LF or CR LF.
                    n = $urandom_range(0, 30);
                    for (int k = 0; k < n; k++)
                        send_byte(pick_no_eol(), -1);
                    case ($urandom_range(0, 2))
                        0: send_byte(CH_CR, -1);
                        1: send_byte(CH_LF, -1);
                        default: begin
                            send_byte(CH_CR, -1);
                            send_byte(CH_LF, -1);
                        end
                    endcase
                end
                2: begin
                    // Raw noise, every byte value allowed.
                    n = $urandom_range(5, 30);
                    for (int k = 0; k < n; k++)
                        send_byte(8'($urandom_range(0, 255)), -1);
                end
                3: begin
                    // Fill an empty frame to capacity minus one, then
                    // overflow it and restart the frame.
                    send_byte(CH_LF, -1);
                    for (int k = 0; k < FRAME_CAP - 1; k++)
                        send_byte(pick_plain(), -1);
                    send_byte(pick_no_eol(), -1);
                    send_byte(pick_plain(), -1);
                end
                default: begin
                    // Push the depth past saturation, back off, end the line.
                    send_byte(CH_LF, -1);
                    for (int k = 0; k < 260; k++)
                        send_byte(CH_OPEN, -1);
                    send_byte(CH_CLOSE, -1);
                    send_byte(CH_CLOSE, -1);
                    send_byte(CH_LF, -1);
                end
            endcase
            seq_no++;
        end

        // Drop valid, let every owed word come back, then wait for anything stray.
        rx_ch.valid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && events_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lojf_pkg.sv
rtl/lojf_if.sv
rtl/lojf_tracker.sv
rtl/lojf_out_buf.sv
rtl/line_or_json_object_framer_top.sv
tb/line_or_json_object_framer_top_tb.sv
